FILE: hdl/qwsc_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// qwsc_pkg
// Shared constants for the quarter-wave polynomial sine/cosine pipeline:
// default formats, pi in Q2.60 and the Horner coefficients in Q2.30.
// ============================================================================
package qwsc_pkg;

    // default fixed-point formats
    localparam int QWSC_ANGLE_FRAC_BITS = 21;
    localparam int QWSC_OUT_FRAC_BITS   = 22;

    // fractional bits of the polynomial datapath
    localparam int POLY_FRAC = 30;

    // pi in Q2.60
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    // Horner coefficients, highest power first, signed Q2.30
    localparam int HORNER_STEPS = 4;
    localparam int COEF_W       = 32;
    localparam logic signed [COEF_W-1:0] POLY_COEF [HORNER_STEPS+1] = '{
        32'sd24861,
        -32'sd1487530,
        32'sd44735933,
        -32'sd536869896,
        32'sd1073741774
    };

endpackage

FILE: hdl/quarter_wave_poly_sine_cosine_top.sv
`timescale 1ns / 1ps
// ============================================================================
// quarter_wave_poly_sine_cosine_top
// Sine or cosine of an angle in [0, 2pi): fold to a quarter-wave driver,
// square it, run an even degree-8 Horner polynomial, round, saturate, sign.
// ============================================================================
//
//  channel   | dir | tdata                 | tuser
//  ----------+-----+-----------------------+-----------------------------
//  s_axis    | in  | angle, unsigned Q3.AF | cmd (0 cosine, 1 sine)
//  m_axis    | out | value, signed Q1.OF   | -
//
//  One request per cycle is taken while the pipe is not stalled. The stages
//  are: clamp, fold, square, scale, then a multiply and a round-add stage for
//  each of the four Horner steps, then the output stage.
//  All stages advance together whenever the output register is empty or
//  being taken, so a stall freezes the pipe without loss. Reset clears the
//  valid bits only.
//
module quarter_wave_poly_sine_cosine_top
    import qwsc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = QWSC_ANGLE_FRAC_BITS,
    parameter int OUT_FRAC_BITS   = QWSC_OUT_FRAC_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // request side
    input  logic i_s_axis_tvalid,
    output logic o_s_axis_tready,
    // [AF+2:0] angle, zero padded to bytes
    input  logic [((ANGLE_FRAC_BITS+3+7)/8)*8-1:0] i_s_axis_tdata,
    // [0] cmd
    input  logic i_s_axis_tuser,
    // result side
    output logic o_m_axis_tvalid,
    input  logic i_m_axis_tready,
    // [OF+1:0] value, zero padded to bytes
    output logic [((OUT_FRAC_BITS+2+7)/8)*8-1:0] o_m_axis_tdata
);

    localparam int AB      = ANGLE_FRAC_BITS + 3;
    localparam int OB      = OUT_FRAC_BITS + 2;
    localparam int OTD_W   = ((OB + 7) / 8) * 8;
    localparam int D_W     = ANGLE_FRAC_BITS + 1;
    localparam int SQ_W    = 2 * D_W;
    localparam int X2_W    = 32;
    localparam int H_W     = 33;
    localparam int P_W     = H_W + X2_W + 1;
    localparam int X2_SH   = 2 * ANGLE_FRAC_BITS - POLY_FRAC;
    localparam int OUT_SH  = POLY_FRAC - OUT_FRAC_BITS;

    // folding constants, rounded to the angle format; the clamp limit is truncated
    localparam logic [63:0] PI_W   =
        (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
    localparam logic [63:0] HALF_W =
        (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
    localparam logic [63:0] TH_W   =
        (64'd3 * PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
    localparam logic [63:0] TWO_W  =
        (PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
    localparam logic [63:0] MAX_W  = PI_Q60 >> (59 - ANGLE_FRAC_BITS);

    localparam logic [AB-1:0] PI_A    = PI_W[AB-1:0];
    localparam logic [AB-1:0] HALF_A  = HALF_W[AB-1:0];
    localparam logic [AB-1:0] TH_A    = TH_W[AB-1:0];
    localparam logic [AB-1:0] TWO_A   = TWO_W[AB-1:0];
    localparam logic [AB-1:0] MAX_A   = MAX_W[AB-1:0];

    localparam logic signed [H_W-1:0] LIM_P = H_W'(1) << OUT_FRAC_BITS;
    localparam logic signed [H_W-1:0] LIM_N = -LIM_P;

    logic w_en;

    // pipeline registers
    logic                   r_v1, r_v2, r_v3, r_v4, r_ov;
    logic [AB-1:0]          r_x1;
    logic                   r_sin1;
    logic [D_W-1:0]         r_d2;
    logic                   r_neg2, r_neg3, r_neg4;
    logic [SQ_W-1:0]        r_sq3;
    logic [X2_W-1:0]        r_x2_4;
    logic [OB-1:0]          r_value;

    logic                   r_mv   [HORNER_STEPS];
    logic signed [P_W-1:0]  r_prod [HORNER_STEPS];
    logic [X2_W-1:0]        r_mx2  [HORNER_STEPS];
    logic                   r_mneg [HORNER_STEPS];
    logic                   r_av   [HORNER_STEPS];
    logic signed [H_W-1:0]  r_h    [HORNER_STEPS];
    logic [X2_W-1:0]        r_ax2  [HORNER_STEPS];
    logic                   r_aneg [HORNER_STEPS];

    // advance everything while the output is free or being taken
    assign w_en            = !r_ov || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = OTD_W'(r_value);

    // stage 1: clamp the angle
    logic [AB-1:0] n_x1;
    always_comb begin
        n_x1 = i_s_axis_tdata[AB-1:0];
        if (n_x1 > MAX_A) begin
            n_x1 = MAX_A;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1   <= n_x1;
            r_sin1 <= i_s_axis_tuser;
        end
    end

    // stage 2: fold to a quarter-wave driver and pick the sign
    logic [AB-1:0] w_k, w_ref, w_dabs;
    logic          w_above_pi, n_neg2;
    always_comb begin
        w_above_pi = r_x1 > PI_A;
        w_k        = r_x1;
        w_ref      = HALF_A;
        w_dabs     = '0;
        n_neg2     = 1'b0;
        if (r_sin1) begin
            n_neg2 = w_above_pi;
            w_ref  = w_above_pi ? TH_A : HALF_A;
            w_dabs = (r_x1 >= w_ref) ? r_x1 - w_ref : w_ref - r_x1;
        end else begin
            w_k    = w_above_pi ? TWO_A - r_x1 : r_x1;
            n_neg2 = w_k >= HALF_A;
            if (n_neg2) begin
                w_dabs = (w_k >= PI_A) ? w_k - PI_A : PI_A - w_k;
            end else begin
                w_dabs = w_k;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2   <= w_dabs[D_W-1:0];
            r_neg2 <= n_neg2;
        end
    end

    // stage 3: square the driver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq3  <= r_d2 * r_d2;
            r_neg3 <= r_neg2;
        end
    end

    // stage 4: bring the square to the polynomial format
    logic [X2_W-1:0] n_x2;
    generate
        if (X2_SH > 0) begin : g_x2_down
            logic [SQ_W:0] w_sq_rnd;
            always_comb begin
                w_sq_rnd = {1'b0, r_sq3} + ((SQ_W+1)'(1) << (X2_SH - 1));
                n_x2     = X2_W'(w_sq_rnd >> X2_SH);
            end
        end else if (X2_SH == 0) begin : g_x2_same
            assign n_x2 = X2_W'(r_sq3);
        end else begin : g_x2_up
            assign n_x2 = X2_W'(r_sq3) << (-X2_SH);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x2_4 <= n_x2;
            r_neg4 <= r_neg3;
        end
    end

    // Horner steps: a multiply stage, then a round-and-add stage
    localparam logic signed [P_W-1:0] P_HALF = P_W'(1) << (POLY_FRAC - 1);

    generate
        for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_horner
            logic                  w_v_in, w_neg_in;
            logic signed [H_W-1:0] w_h_in;
            logic [X2_W-1:0]       w_x2_in;
            logic signed [P_W-1:0] w_prod_rnd;
            logic signed [P_W-1:0] w_prod_sh;

            if (j == 0) begin : g_first
                assign w_v_in   = r_v4;
                assign w_neg_in = r_neg4;
                assign w_h_in   = H_W'(POLY_COEF[0]);
                assign w_x2_in  = r_x2_4;
            end else begin : g_next
                assign w_v_in   = r_av[j-1];
                assign w_neg_in = r_aneg[j-1];
                assign w_h_in   = r_h[j-1];
                assign w_x2_in  = r_ax2[j-1];
            end

            // multiply stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_mv[j] <= 1'b0;
                end else if (w_en) begin
                    r_mv[j] <= w_v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_prod[j] <= P_W'(w_h_in) * P_W'($signed({1'b0, w_x2_in}));
                    r_mx2[j]  <= w_x2_in;
                    r_mneg[j] <= w_neg_in;
                end
            end

            // round the product to Q.30 and add the next coefficient
            assign w_prod_rnd = r_prod[j] + P_HALF;
            assign w_prod_sh  = w_prod_rnd >>> POLY_FRAC;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_av[j] <= 1'b0;
                end else if (w_en) begin
                    r_av[j] <= r_mv[j];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_h[j]    <= H_W'(POLY_COEF[j+1]) + w_prod_sh[H_W-1:0];
                    r_ax2[j]  <= r_mx2[j];
                    r_aneg[j] <= r_mneg[j];
                end
            end
        end
    endgenerate

    // output stage: round to the output format, saturate, apply the sign
    logic signed [H_W-1:0] w_y_rnd;
    logic signed [H_W-1:0] w_y_sat;
    generate
        if (OUT_SH > 0) begin : g_out_round
            logic signed [H_W-1:0] w_y_sum;
            assign w_y_sum = r_h[HORNER_STEPS-1] + (H_W'(1) <<< (OUT_SH - 1));
            assign w_y_rnd = w_y_sum >>> OUT_SH;
        end else begin : g_out_keep
            assign w_y_rnd = r_h[HORNER_STEPS-1];
        end
    endgenerate

    always_comb begin
        w_y_sat = w_y_rnd;
        if (w_y_rnd > LIM_P) begin
            w_y_sat = LIM_P;
        end else if (w_y_rnd < LIM_N) begin
            w_y_sat = LIM_N;
        end
        if (r_aneg[HORNER_STEPS-1]) begin
            w_y_sat = -w_y_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_av[HORNER_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value <= w_y_sat[OB-1:0];
        end
    end

endmodule
